FILE: rtl/sfuvn_pkg.sv
package sfuvn_pkg;

    // compare width wide enough for any index against any vertex count
    localparam int CMP_W = 17;
    // quotient register: 33-bit magnitude scaled by 2^16
    localparam int DQ_W = 49;
    localparam int CNT_W = 6;
    // 1.0 in Q16.16, used when a span is zero or negative
    localparam logic [32:0] Q_ONE = 33'd65536;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_FACE   = 3'd1,
        ACT_STORE  = 3'd2,
        ACT_BOUNDS = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        index_a;
        logic [15:0]        index_b;
        logic [15:0]        index_c;
        logic               face_selected;
        logic signed [31:0] u_in;
        logic signed [31:0] v_in;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [15:0]        vertex_index;
        logic               was_touched;
        logic signed [31:0] u_out;
        logic signed [31:0] v_out;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIPE,
        ST_FACE_A,
        ST_FACE_B,
        ST_FACE_C,
        ST_SCAN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DIV_U,
        ST_V_GO,
        ST_DIV_V
    } ctl_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_PREP,
        DV_ITER,
        DV_FIX
    } div_state_t;

endpackage

FILE: rtl/sfuvn_div.sv
module sfuvn_div
    import sfuvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [31:0] x,
    input  logic signed [31:0] lo,
    input  logic signed [31:0] hi,
    output logic               done,
    output logic signed [31:0] q
);

    div_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [32:0]      d_reg;
    logic [32:0]      r_reg;
    logic             neg_reg;
    logic [DQ_W-1:0]  dq_reg;
    logic [32:0]      den_reg;
    logic [32:0]      rem_reg;
    logic [33:0]      trial;
    logic [32:0]      mag;
    logic             pos_ovf;
    logic             neg_ovf;

    // one quotient bit per cycle: shift in the next dividend bit, try a subtract
    assign trial = {rem_reg, dq_reg[DQ_W-1]} - {1'b0, den_reg};
    assign mag   = d_reg[32] ? (~d_reg + 33'd1) : d_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (go) state_next = DV_PREP;
            DV_PREP: state_next = DV_ITER;
            DV_ITER: if (cnt_reg == CNT_W'(DQ_W - 1)) state_next = DV_FIX;
            DV_FIX:  state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    // outputs: saturate the magnitude and apply the sign
    always_comb
    begin
        pos_ovf = |dq_reg[DQ_W-1:31];
        neg_ovf = (|dq_reg[DQ_W-1:32]) || (dq_reg[31] && (|dq_reg[30:0]));
        done    = (state_reg == DV_FIX);
        if (neg_reg)
            q = neg_ovf ? 32'sh8000_0000 : $signed(~dq_reg[31:0] + 32'd1);
        else
            q = pos_ovf ? 32'sh7FFF_FFFF : $signed(dq_reg[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DV_PREP)
                cnt_reg <= '0;
            else if (state_reg == DV_ITER)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // load differences, form magnitude and divisor, then iterate
    always_ff @(posedge clk)
    begin
        case (state_reg)
            DV_IDLE:
            begin
                if (go)
                begin
                    d_reg <= {x[31], x} - {lo[31], lo};
                    r_reg <= {hi[31], hi} - {lo[31], lo};
                end
            end
            DV_PREP:
            begin
                neg_reg <= d_reg[32];
                dq_reg  <= {mag, 16'd0};
                den_reg <= ((r_reg == 33'd0) || r_reg[32]) ? Q_ONE : r_reg;
                rem_reg <= '0;
            end
            DV_ITER:
            begin
                if (!trial[33])
                    rem_reg <= trial[32:0];
                else
                    rem_reg <= {rem_reg[31:0], dq_reg[DQ_W-1]};
                dq_reg <= {dq_reg[DQ_W-2:0], ~trial[33]};
            end
            default:
            begin
            end
        endcase
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("divider done held longer than one cycle");
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DV_ITER) |-> (den_reg != 33'd0))
        else $error("divider iterating with zero divisor");
    a_done_after_iter: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == DV_ITER))
        else $error("divider finished without iterating");

endmodule

FILE: rtl/selected_face_uv_range_normalizer.sv
// channel   ports                     direction  beat marked by
// command   cmd (cmd_t)               in         start & !busy
// result    result (result_t)         out        strobe, one cycle
// config    cfg_wdata[12:0]           in         cfg_we
//
// Store writes on accept, busy staying low; face load steps FACE_A to FACE_C;
// clear wipes the touched map; bounds scan covers the clamped vertex count,
// one touched-map and UV memory read per cycle. Read passes RD_ADDR and
// RD_DATA; when normalizing, the serial divider makes one quotient bit per
// cycle, 49 bits for u and then for v. After reset the map is wiped, busy high.
// Results cannot be stalled: strobe is a single-cycle pulse.
module selected_face_uv_range_normalizer
    import sfuvn_pkg::*;
#(
    parameter int MAX_VERTICES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    output logic        strobe,
    output result_t     result
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_VERTICES);

    ctl_state_t         state_reg, state_next;
    cmd_t               cmd_reg;
    logic [12:0]        vcount_reg;
    logic [IDX_W-1:0]   wipe_reg;
    logic [IDX_W:0]     scan_reg;
    logic               pend_reg;
    logic               any_reg;
    logic               bval_reg;
    logic signed [31:0] ul_reg, uh_reg, vl_reg, vh_reg;
    logic signed [31:0] u_low_reg, u_high_reg, v_low_reg, v_high_reg;
    logic signed [31:0] rd_u_reg, rd_v_reg;
    logic               strobe_reg;
    result_t            result_reg;

    logic               tm_mem [MAX_VERTICES];
    logic [63:0]        uv_mem [MAX_VERTICES];
    logic               tm_rdata_reg;
    logic [63:0]        uv_rdata_reg;

    logic               accept;
    logic [CMP_W-1:0]   n_wide;
    logic [CMP_W-1:0]   vc_wide;
    logic [15:0]        face_idx;
    logic               tm_we;
    logic               tm_wdata;
    logic [IDX_W-1:0]   tm_waddr;
    logic [IDX_W-1:0]   raddr;
    logic               uv_we;
    logic               scan_issue;
    logic               scan_end;
    logic               wipe_last;
    logic               rd_in_range;
    logic               rd_touched;
    logic               need_div;
    logic               div_go;
    logic               div_done;
    logic signed [31:0] div_x, div_lo, div_hi, div_q;
    logic               emit;
    result_t            result_next;
    logic signed [31:0] scan_u, scan_v;

    assign accept      = start && !busy;
    assign vc_wide     = CMP_W'(vcount_reg);
    assign n_wide      = (vc_wide < MAX_W) ? vc_wide : MAX_W;
    assign wipe_last   = (wipe_reg == IDX_W'(MAX_VERTICES - 1));
    assign rd_in_range = ({1'b0, cmd_reg.index_a} < MAX_W);
    assign rd_touched  = rd_in_range && tm_rdata_reg;
    assign need_div    = rd_touched && bval_reg;
    assign scan_issue  = (state_reg == ST_SCAN) && (CMP_W'(scan_reg) < n_wide);
    assign scan_end    = (state_reg == ST_SCAN) && !scan_issue && !pend_reg;
    assign uv_we       = accept && (cmd.action == ACT_STORE) && ({1'b0, cmd.index_a} < MAX_W);
    assign scan_u      = $signed(uv_rdata_reg[63:32]);
    assign scan_v      = $signed(uv_rdata_reg[31:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.action)
                        ACT_CLEAR:  state_next = ST_WIPE;
                        ACT_FACE:   state_next = ST_FACE_A;
                        ACT_BOUNDS: state_next = ST_SCAN;
                        ACT_READ:   state_next = ST_RD_ADDR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WIPE:    if (wipe_last) state_next = ST_IDLE;
            ST_FACE_A:  state_next = ST_FACE_B;
            ST_FACE_B:  state_next = ST_FACE_C;
            ST_FACE_C:  state_next = ST_IDLE;
            ST_SCAN:    if (scan_end) state_next = ST_IDLE;
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = need_div ? ST_DIV_U : ST_IDLE;
            ST_DIV_U:   if (div_done) state_next = ST_V_GO;
            ST_V_GO:    state_next = ST_DIV_V;
            ST_DIV_V:   if (div_done) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        face_idx    = cmd_reg.index_a;
        tm_we       = 1'b0;
        tm_wdata    = 1'b0;
        tm_waddr    = wipe_reg;
        raddr       = cmd_reg.index_a[IDX_W-1:0];
        div_go      = 1'b0;
        div_x       = rd_v_reg;
        div_lo      = v_low_reg;
        div_hi      = v_high_reg;
        emit        = 1'b0;
        result_next = '0;
        unique case (state_reg)
            ST_WIPE:
            begin
                tm_we = 1'b1;
            end
            ST_FACE_A, ST_FACE_B, ST_FACE_C:
            begin
                if (state_reg == ST_FACE_B)
                    face_idx = cmd_reg.index_b;
                else if (state_reg == ST_FACE_C)
                    face_idx = cmd_reg.index_c;
                tm_we    = cmd_reg.face_selected && ({1'b0, face_idx} < n_wide);
                tm_wdata = 1'b1;
                tm_waddr = face_idx[IDX_W-1:0];
            end
            ST_SCAN:
            begin
                raddr = scan_reg[IDX_W-1:0];
                if (scan_end)
                begin
                    emit           = 1'b1;
                    result_next.ok = any_reg;
                end
            end
            ST_RD_DATA:
            begin
                div_x  = scan_u;
                div_lo = u_low_reg;
                div_hi = u_high_reg;
                div_go = need_div;
                if (!need_div)
                begin
                    emit                     = 1'b1;
                    result_next.ok           = bval_reg;
                    result_next.vertex_index = cmd_reg.index_a;
                    result_next.was_touched  = rd_touched;
                    result_next.u_out        = rd_in_range ? scan_u : 32'sd0;
                    result_next.v_out        = rd_in_range ? scan_v : 32'sd0;
                end
            end
            ST_V_GO:
            begin
                div_go = 1'b1;
            end
            ST_DIV_V:
            begin
                if (div_done)
                begin
                    emit                     = 1'b1;
                    result_next.ok           = bval_reg;
                    result_next.vertex_index = cmd_reg.index_a;
                    result_next.was_touched  = 1'b1;
                    result_next.u_out        = rd_u_reg;
                    result_next.v_out        = div_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    // touched map and UV store, registered reads
    always_ff @(posedge clk)
    begin
        if (tm_we)
            tm_mem[tm_waddr] <= tm_wdata;
        tm_rdata_reg <= tm_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (uv_we)
            uv_mem[cmd.index_a[IDX_W-1:0]] <= {cmd.u_in, cmd.v_in};
        uv_rdata_reg <= uv_mem[raddr];
    end

    sfuvn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .x     (div_x),
        .lo    (div_lo),
        .hi    (div_hi),
        .done  (div_done),
        .q     (div_q)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_WIPE;
            vcount_reg <= '0;
            wipe_reg   <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
            any_reg    <= 1'b0;
            bval_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            u_low_reg  <= '0;
            u_high_reg <= '0;
            v_low_reg  <= '0;
            v_high_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= emit;
            if (cfg_we)
                vcount_reg <= cfg_wdata;

            // advance the wipe sweep
            if (state_reg == ST_WIPE)
                wipe_reg <= wipe_last ? '0 : wipe_reg + IDX_W'(1);

            if (accept && (cmd.action == ACT_CLEAR))
                bval_reg <= 1'b0;

            // advance the scan; hold one read in flight
            if (accept && (cmd.action == ACT_BOUNDS))
            begin
                scan_reg <= '0;
                any_reg  <= 1'b0;
            end
            else if (scan_issue)
                scan_reg <= scan_reg + (IDX_W + 1)'(1);
            pend_reg <= scan_issue;
            if (pend_reg && tm_rdata_reg)
                any_reg <= 1'b1;

            if (scan_end)
            begin
                bval_reg <= any_reg;
                if (any_reg)
                begin
                    u_low_reg  <= ul_reg;
                    u_high_reg <= uh_reg;
                    v_low_reg  <= vl_reg;
                    v_high_reg <= vh_reg;
                end
            end
        end
    end

    // payload: command, scan extremes, read values, result beat
    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (pend_reg && tm_rdata_reg)
        begin
            if (!any_reg || (scan_u < ul_reg)) ul_reg <= scan_u;
            if (!any_reg || (scan_u > uh_reg)) uh_reg <= scan_u;
            if (!any_reg || (scan_v < vl_reg)) vl_reg <= scan_v;
            if (!any_reg || (scan_v > vh_reg)) vh_reg <= scan_v;
        end
        if (state_reg == ST_RD_DATA)
            rd_v_reg <= scan_v;
        if ((state_reg == ST_DIV_U) && div_done)
            rd_u_reg <= div_q;
        if (emit)
            result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result beat without a command in progress");
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        bval_reg |-> ((u_low_reg <= u_high_reg) && (v_low_reg <= v_high_reg)))
        else $error("valid bounds with low above high");
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("scan read pending outside the scan");

endmodule

FILE: sim/tb_selected_face_uv_range_normalizer.sv
module tb_selected_face_uv_range_normalizer;
    import sfuvn_pkg::*;

    localparam int NVERT = 4096;
    localparam longint CYCLE_LIMIT = 64'd40000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    cmd_t        cmd;
    logic        busy;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        strobe;
    result_t     result;

    selected_face_uv_range_normalizer #(.MAX_VERTICES(NVERT)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .strobe    (strobe),
        .result    (result)
    );

    // predictor state
    bit                 touched_bits [NVERT];
    logic signed [31:0] store_u [NVERT];
    logic signed [31:0] store_v [NVERT];
    bit                 written [NVERT];
    logic signed [31:0] lo_u, hi_u, lo_v, hi_v;
    bit                 have_bounds;
    int unsigned        vcount;

    cmd_t    pending_cmds [$];
    result_t expected_results [$];
    int      errors;
    longint  cycle_count;
    int      idle_pct;
    bit      hold_sender;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] scale_to_range(logic signed [31:0] x,
                                                          logic signed [31:0] lo,
                                                          logic signed [31:0] hi);
        longint d;
        longint r;
        longint q;
        d = longint'(x) - longint'(lo);
        r = longint'(hi) - longint'(lo);
        if (r <= 0)
            r = 65536;
        q = (d * 65536) / r;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q[31:0];
    endfunction

    // advance the predictor by one accepted command
    task automatic predict_command(input cmd_t c);
        int unsigned n;
        bit          any;
        result_t     r;
        n = (vcount < NVERT) ? vcount : NVERT;
        r = '0;
        case (c.action)
            ACT_CLEAR:
            begin
                foreach (touched_bits[i])
                    touched_bits[i] = 0;
                have_bounds = 0;
            end
            ACT_FACE:
            begin
                if (c.face_selected)
                begin
                    if (c.index_a < n) touched_bits[c.index_a] = 1;
                    if (c.index_b < n) touched_bits[c.index_b] = 1;
                    if (c.index_c < n) touched_bits[c.index_c] = 1;
                end
            end
            ACT_STORE:
            begin
                if (c.index_a < NVERT)
                begin
                    store_u[c.index_a] = c.u_in;
                    store_v[c.index_a] = c.v_in;
                end
            end
            ACT_BOUNDS:
            begin
                logic signed [31:0] ul, uh, vl, vh;
                any = 0;
                ul = 0; uh = 0; vl = 0; vh = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!touched_bits[i])
                        continue;
                    if (!any)
                    begin
                        ul = store_u[i]; uh = store_u[i];
                        vl = store_v[i]; vh = store_v[i];
                        any = 1;
                    end
                    else
                    begin
                        if (store_u[i] < ul) ul = store_u[i];
                        if (store_u[i] > uh) uh = store_u[i];
                        if (store_v[i] < vl) vl = store_v[i];
                        if (store_v[i] > vh) vh = store_v[i];
                    end
                end
                if (any)
                begin
                    lo_u = ul; hi_u = uh; lo_v = vl; hi_v = vh;
                end
                have_bounds = any;
                r.ok = any;
                expected_results.push_back(r);
            end
            ACT_READ:
            begin
                r.ok = have_bounds;
                r.vertex_index = c.index_a;
                if (c.index_a < NVERT)
                begin
                    r.was_touched = touched_bits[c.index_a];
                    r.u_out = store_u[c.index_a];
                    r.v_out = store_v[c.index_a];
                    if (r.was_touched && have_bounds)
                    begin
                        r.u_out = scale_to_range(store_u[c.index_a], lo_u, hi_u);
                        r.v_out = scale_to_range(store_v[c.index_a], lo_v, hi_v);
                    end
                end
                expected_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // drive commands from the pending queue, one beat per accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
                predict_command(cmd);
            if (start && busy)
                ; // hold the current beat
            else if (pending_cmds.size() > 0 && !hold_sender
                     && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                cmd   <= pending_cmds.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // check every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, result);
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (e.ok !== result.ok)
                    $display("%0t: ok exp %0d got %0d", $time, e.ok, result.ok);
                if (e.vertex_index !== result.vertex_index)
                    $display("%0t: vertex_index exp %0d got %0d", $time,
                             e.vertex_index, result.vertex_index);
                if (e.was_touched !== result.was_touched)
                    $display("%0t: was_touched exp %0d got %0d", $time,
                             e.was_touched, result.was_touched);
                if (e.u_out !== result.u_out)
                    $display("%0t: u_out exp %0d got %0d", $time, e.u_out, result.u_out);
                if (e.v_out !== result.v_out)
                    $display("%0t: v_out exp %0d got %0d", $time, e.v_out, result.v_out);
                if (e !== result)
                    errors++;
            end
        end
    end

    // stop on a runaway run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly a written vertex of the span, else one at or above the count
    function automatic logic [15:0] pick_vertex(int unsigned span, int unsigned n);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 85)
            return 16'($urandom_range(span - 1));
        return 16'($urandom_range(32'hFFFF - n) + n);
    endfunction

    function automatic logic signed [31:0] pick_coord();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return 32'sh7FFFFFFF;
        if (k == 1) return 32'sh80000000;
        if (k < 5)  return $urandom;
        return $signed($urandom_range(32'h00040000)) - 32'sh00020000;
    endfunction

    function automatic cmd_t make_cmd(action_t a, logic [15:0] ia, logic [15:0] ib,
                                      logic [15:0] ic, logic s,
                                      logic signed [31:0] u, logic signed [31:0] v);
        cmd_t c;
        c.action = a;
        c.index_a = ia; c.index_b = ib; c.index_c = ic;
        c.face_selected = s;
        c.u_in = u; c.v_in = v;
        return c;
    endfunction

    // let queued work drain, then allow for a trailing clear or scan
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (NVERT + 20) @(posedge clk);
    endtask

    task automatic write_count(input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[12:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        vcount = value;
    endtask

    // write any unwritten vertex of the span, then a burst of random work on it
    task automatic random_phase(input int unsigned span, input int items);
        cmd_t        c;
        int          k;
        int unsigned n;
        n = (vcount < NVERT) ? vcount : NVERT;
        for (int i = 0; i < span; i++)
        begin
            if (!written[i])
            begin
                written[i] = 1;
                pending_cmds.push_back(make_cmd(ACT_STORE, 16'(i), 16'($urandom),
                                                16'($urandom), 1'($urandom),
                                                pick_coord(), pick_coord()));
            end
        end
        for (int i = 0; i < items; i++)
        begin
            k = $urandom_range(99);
            if (k < 4)
                c = make_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                             1'($urandom), $urandom, $urandom);
            else if (k < 35)
                c = make_cmd(ACT_FACE, pick_vertex(span, n), pick_vertex(span, n),
                             pick_vertex(span, n), $urandom_range(9) != 0,
                             $urandom, $urandom);
            else if (k < 50)
                c = make_cmd(ACT_STORE, $urandom_range(99) < 95 ? pick_vertex(span, n)
                             : 16'(16'hFFFF - $urandom_range(100)), 16'($urandom),
                             16'($urandom), 1'($urandom), pick_coord(), pick_coord());
            else if (k < 58)
                c = make_cmd(ACT_BOUNDS, 16'($urandom), 16'($urandom), 16'($urandom),
                             1'($urandom), $urandom, $urandom);
            else if (k < 97)
                c = make_cmd(ACT_READ, $urandom_range(99) < 95
                             ? 16'($urandom_range(span - 1))
                             : 16'($urandom_range(16'hFFFF - NVERT) + NVERT),
                             16'($urandom), 16'($urandom), 1'($urandom),
                             $urandom, $urandom);
            else
                c = make_cmd(action_t'(3'd5 + $urandom_range(2)), 16'($urandom),
                             16'($urandom), 16'($urandom), 1'($urandom),
                             $urandom, $urandom);
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        errors = 0;
        cycle_count = 0;
        idle_pct = 0;
        hold_sender = 1'b0;
        vcount = 0;
        have_bounds = 0;
        lo_u = 0; hi_u = 0; lo_v = 0; hi_v = 0;
        foreach (touched_bits[i])
        begin
            touched_bits[i] = 0;
            written[i] = 0;
            store_u[i] = 0;
            store_v[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // directed: count of zero, so faces mark nothing and bounds are empty
        write_count(0);
        for (int i = 0; i < 4; i++)
            pending_cmds.push_back(make_cmd(ACT_STORE, 16'(i), 0, 0, 0,
                                            i[0] ? 32'sh7FFFFFFF : 32'sh80000000,
                                            32'sh00010000 * i));
        pending_cmds.push_back(make_cmd(ACT_FACE, 0, 1, 2, 1'b1, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_BOUNDS, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_STORE, 16'hFFFF, 0, 0, 0, 32'sh12345678, 1));
        pending_cmds.push_back(make_cmd(ACT_READ, 16'hFFFF, 0, 0, 0, 0, 0));
        wait_idle();

        // directed: full extremes, unselected face, out-of-range index, zero span
        write_count(8);
        pending_cmds.push_back(make_cmd(ACT_FACE, 0, 1, 2, 1'b0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_BOUNDS, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_FACE, 0, 1, 16'hFFFF, 1'b1, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_BOUNDS, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_STORE, 1, 0, 0, 0, 32'sh40000000, 32'sh7FFFFFFF));
        pending_cmds.push_back(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_READ, 1, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_FACE, 2, 2, 2, 1'b1, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_BOUNDS, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(ACT_READ, 2, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(action_t'(3'd7), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                        -1, -1));
        wait_idle();

        // random phases, sender idling 11 then 75 then 0 percent
        idle_pct = 11;
        write_count(16);
        random_phase(16, 450);
        wait_idle();
        idle_pct = 75;
        write_count(NVERT);
        random_phase(48, 150);
        wait_idle();
        idle_pct = 0;
        write_count(13'h1FFF);
        random_phase(48, 150);
        wait_idle();
        write_count(24);
        random_phase(24, 500);
        // pause the sender until all results are in, then resume
        repeat (200) @(posedge clk);
        hold_sender = 1'b1;
        while (start || busy || expected_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        random_phase(24, 500);
        wait_idle();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sfuvn_pkg.sv
rtl/sfuvn_div.sv
rtl/selected_face_uv_range_normalizer.sv
sim/tb_selected_face_uv_range_normalizer.sv
